>>> sv/sfr_pkg.sv
// sfr_pkg: constants, enums and command/status structs for the serial frame receiver
// no dependencies
`default_nettype none

package sfr_pkg;

  localparam int unsigned MAX_PAIRS = 32;
  localparam int unsigned ADDR_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned WIDX_W    = (ADDR_W > 6) ? ADDR_W : 6;
  localparam int unsigned WIDX_SAT  = 63;
  localparam int unsigned TDATA_W   = 24;

  localparam logic [7:0] SYNC_A = 8'hFF;
  localparam logic [7:0] SYNC_B = 8'h7F;

  typedef enum logic [1:0] {
    FS_PAIR_OK  = 2'd0,
    FS_CSUM_ERR = 2'd1,
    FS_EMPTY    = 2'd2,
    FS_TOO_LONG = 2'd3
  } frame_status_e;

  typedef enum logic [2:0] {
    S_HUNT,
    S_SYNC,
    S_COUNT,
    S_BODY,
    S_READ,
    S_SEND
  } ctrl_state_e;

  typedef struct packed {
    logic ld_count;
    logic body_byte;
    logic frame_end;
    logic ld_verdict;
    logic rd_start;
    logic rd_next;
    logic ld_pair;
  } cmd_t;

  typedef struct packed {
    logic          is_sync_a;
    logic          is_sync_b;
    logic          body_done;
    frame_status_e verdict;
    logic          out_free;
    logic          rd_last;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/sfr_ram.sv
// sfr_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/sfr_ctrl.sv
// sfr_ctrl: sync hunt, frame body and result emission state machine
// depends on sfr_pkg
`default_nettype none

module sfr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire sfr_pkg::stat_t stat_i,
  output sfr_pkg::cmd_t      cmd_o
);
  import sfr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      S_HUNT: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i && stat_i.is_sync_a) begin
          state_d = S_SYNC;
        end
      end
      S_SYNC: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (stat_i.is_sync_b) begin
            state_d = S_COUNT;
          end else if (stat_i.is_sync_a) begin
            state_d = S_SYNC;
          end else begin
            state_d = S_HUNT;
          end
        end
      end
      S_COUNT: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.ld_count = 1'b1;
          state_d        = S_BODY;
        end
      end
      S_BODY: begin
        s_tready_o = !stat_i.body_done || stat_i.out_free;
        if (s_tvalid_i && s_tready_o) begin
          if (stat_i.body_done) begin
            cmd_o.frame_end = 1'b1;
            if (stat_i.verdict == FS_PAIR_OK) begin
              cmd_o.rd_start = 1'b1;
              state_d        = S_READ;
            end else begin
              cmd_o.ld_verdict = 1'b1;
              state_d          = S_HUNT;
            end
          end else begin
            cmd_o.body_byte = 1'b1;
          end
        end
      end
      S_READ: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (stat_i.out_free) begin
          cmd_o.ld_pair = 1'b1;
          if (stat_i.rd_last) begin
            state_d = S_HUNT;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: begin
        state_d = S_HUNT;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/sfr_dp.sv
// sfr_dp: frame counters, checksum, pair stores and output register
// depends on sfr_pkg and sfr_ram
`default_nettype none

module sfr_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [7:0]                   s_tdata_i,
  input  wire sfr_pkg::cmd_t                cmd_i,
  output sfr_pkg::stat_t                    stat_o,
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic [sfr_pkg::TDATA_W-1:0]       m_tdata_o,
  output logic [1:0]                        m_tuser_o,
  output logic                              m_tlast_o
);
  import sfr_pkg::*;

  localparam logic [7:0]        MAX_PAIRS_B = 8'(MAX_PAIRS);
  localparam logic [WIDX_W-1:0] MAX_IDX     = WIDX_W'(MAX_PAIRS);
  localparam logic [WIDX_W-1:0] IDX_SAT     = WIDX_W'(WIDX_SAT);

  logic [8:0]        bytes_left_q, bytes_left_d;
  logic [7:0]        pair_total_q, pair_total_d;
  logic [7:0]        sum_q, sum_d;
  logic              param_half_q, param_half_d;
  logic [WIDX_W-1:0] widx_q, widx_d;
  logic [ADDR_W-1:0] rd_idx_q, rd_idx_d;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [7:0]        out_cmd_q;
  logic [7:0]        out_par_q;
  logic [4:0]        out_idx_q;
  logic              out_last_q;

  logic              store_ok;
  logic              we_cmd, we_par;
  logic [7:0]        cmd_rdata, par_rdata;
  frame_status_e     verdict;

  assign store_ok = (pair_total_q <= MAX_PAIRS_B) && (widx_q < MAX_IDX);
  assign we_cmd   = cmd_i.body_byte && store_ok && !param_half_q;
  assign we_par   = cmd_i.body_byte && store_ok && param_half_q;

  always_comb begin
    if (pair_total_q > MAX_PAIRS_B) begin
      verdict = FS_TOO_LONG;
    end else if (sum_q != s_tdata_i) begin
      verdict = FS_CSUM_ERR;
    end else if (pair_total_q == 8'd0) begin
      verdict = FS_EMPTY;
    end else begin
      verdict = FS_PAIR_OK;
    end
  end

  always_comb begin
    stat_o.is_sync_a = (s_tdata_i == SYNC_A);
    stat_o.is_sync_b = (s_tdata_i == SYNC_B);
    stat_o.body_done = (bytes_left_q <= 9'd1);
    stat_o.verdict   = verdict;
    stat_o.out_free  = !out_valid_q || m_tready_i;
    stat_o.rd_last   = (8'(rd_idx_q) == (pair_total_q - 8'd1));
  end

  always_comb begin
    bytes_left_d = bytes_left_q;
    pair_total_d = pair_total_q;
    sum_d        = sum_q;
    param_half_d = param_half_q;
    widx_d       = widx_q;
    rd_idx_d     = rd_idx_q;
    if (cmd_i.ld_count) begin
      pair_total_d = s_tdata_i;
      sum_d        = SYNC_A + SYNC_B + s_tdata_i;
      bytes_left_d = {s_tdata_i, 1'b1};
      param_half_d = 1'b0;
      widx_d       = '0;
    end
    if (cmd_i.body_byte) begin
      sum_d        = sum_q + s_tdata_i;
      bytes_left_d = bytes_left_q - 9'd1;
      param_half_d = !param_half_q;
      if (param_half_q && (widx_q < IDX_SAT)) begin
        widx_d = widx_q + 1'b1;
      end
    end
    if (cmd_i.frame_end) begin
      bytes_left_d = '0;
      param_half_d = 1'b0;
      widx_d       = '0;
    end
    if (cmd_i.rd_start) begin
      rd_idx_d = '0;
    end
    if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      pair_total_q <= '0;
      sum_q        <= '0;
      param_half_q <= 1'b0;
      widx_q       <= '0;
      rd_idx_q     <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      pair_total_q <= pair_total_d;
      sum_q        <= sum_d;
      param_half_q <= param_half_d;
      widx_q       <= widx_d;
      rd_idx_q     <= rd_idx_d;
    end
  end

  sfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAIRS)
  ) u_cmd_ram (
    .clk_i  (clk_i),
    .we_i   (we_cmd),
    .waddr_i(widx_q[ADDR_W-1:0]),
    .wdata_i(s_tdata_i),
    .raddr_i(rd_idx_q),
    .rdata_o(cmd_rdata)
  );

  sfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAIRS)
  ) u_par_ram (
    .clk_i  (clk_i),
    .we_i   (we_par),
    .waddr_i(widx_q[ADDR_W-1:0]),
    .wdata_i(s_tdata_i),
    .raddr_i(rd_idx_q),
    .rdata_o(par_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_verdict || cmd_i.ld_pair) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_verdict) begin
      out_status_q <= verdict;
      out_cmd_q    <= '0;
      out_par_q    <= '0;
      out_idx_q    <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.ld_pair) begin
      out_status_q <= FS_PAIR_OK;
      out_cmd_q    <= cmd_rdata;
      out_par_q    <= par_rdata;
      out_idx_q    <= 5'(rd_idx_q);
      out_last_q   <= stat_o.rd_last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {3'b000, out_idx_q, out_par_q, out_cmd_q};
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;

endmodule

`default_nettype wire

>>> sv/serial_frame_receiver_core.sv
// serial_frame_receiver_core: top level of the sync/count/checksum frame receiver
// depends on sfr_pkg, sfr_ctrl, sfr_dp (which uses sfr_ram)
//
//   channel  dir  tdata                                        tuser       tlast
//   s_axis   in   [7:0] rx_byte                                -           -
//   m_axis   out  [7:0] command [15:8] parameter_res           [1:0]       last_result
//                 [20:16] pair_index [23:21] zero              status
//
// one cycle per received byte while s_axis_tready is high; the checksum byte of a frame with a bad sum,
// no pairs or too many pairs yields one result from the output register
// a good frame then emits its pairs one by one, each by a registered ram read
// then an output register load; s_axis_tready is low for that whole stretch
// the checksum byte waits while the output register is full and stalled
// reset clears control state only; the pair stores need no clearing pass
`default_nettype none

module serial_frame_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] command, [15:8] parameter_res, [20:16] pair_index
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  output logic             m_axis_tlast    // last_result
);
  import sfr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sfr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sfr_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser),
    .m_tlast_o (m_axis_tlast)
  );

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ld_pair || cmd.ld_verdict) |-> stat.out_free)
    else $error("output register loaded while full");

  a_verdict_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ld_verdict |=> (m_axis_tvalid && m_axis_tlast && m_axis_tuser != FS_PAIR_OK))
    else $error("status-only result not presented");

  a_last_pair_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ld_pair && stat.rd_last) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final pair not marked last");

  a_no_input_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_start || cmd.rd_next) |=> !s_axis_tready)
    else $error("input accepted during pair emission");

endmodule

`default_nettype wire
